// ===== sv/fslc_pkg.sv =====
// Package for the frame-stamped LRU texture cache: widths, codes and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package fslc_pkg;

  localparam int EntryCount    = 129;
  localparam int SlotW         = 8;
  localparam int KeyW          = 48;
  localparam int StampW        = 32;
  localparam int OutcomeW      = 3;
  localparam int ThreshW       = 11;
  localparam int ThresholdDef  = 128;

  localparam logic [SlotW-1:0]  LastSlot  = SlotW'(EntryCount - 1);
  localparam logic [StampW-1:0] FrameTop  = '1;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdTick   = 1'b1;

  localparam logic [OutcomeW-1:0] OutHit     = 3'd0;
  localparam logic [OutcomeW-1:0] OutStored  = 3'd1;
  localparam logic [OutcomeW-1:0] OutEvicted = 3'd2;
  localparam logic [OutcomeW-1:0] OutNoRoom  = 3'd3;
  localparam logic [OutcomeW-1:0] OutTick    = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic finish;
  } fslc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } fslc_sts_t;

endpackage

`default_nettype wire

// ===== sv/fslc_req_if.sv =====
// Request channel: valid/ready handshake carrying command and lookup key.
// Depends on fslc_pkg.
`default_nettype none

interface fslc_req_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [fslc_pkg::KeyW-1:0] lookup_key;

  modport source (output valid, output cmd, output lookup_key, input ready);
  modport sink   (input valid, input cmd, input lookup_key, output ready);
endinterface

`default_nettype wire

// ===== sv/fslc_rsp_if.sv =====
// Response channel: valid/ready handshake carrying outcome, slot and evicted key.
// Depends on fslc_pkg.
`default_nettype none

interface fslc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fslc_pkg::OutcomeW-1:0] outcome;
  logic [fslc_pkg::SlotW-1:0]    slot;
  logic [fslc_pkg::KeyW-1:0]     evicted_key;

  modport source (output valid, output outcome, output slot, output evicted_key,
                  input ready);
  modport sink   (input valid, input outcome, input slot, input evicted_key,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/frame_stamped_lru_texture_cache_top.sv =====
// Top level of the frame-stamped LRU texture cache: controller and datapath.
// Depends on fslc_pkg, fslc_req_if, fslc_rsp_if, fslc_ctrl, fslc_dp.
//
//   channel  dir  beat payload
//   req_i    in   cmd, lookup_key
//   rsp_o    out  outcome, slot, evicted_key
//
// A frame tick goes from accept to commit (S_FIN); a lookup first scans the key and
// stamp memories one entry per cycle through all 129 entries (S_SCAN), then
// passes a read-latency state (S_LAST) and commit (S_FIN), where its result is
// registered. One beat is in work at a time; a new beat is taken while the previous
// result waits in the output register, and commit holds until that result is taken.
// Reset clears valid bits, occupancy and frame counter at once; no clearing pass.
`default_nettype none

module frame_stamped_lru_texture_cache_top #(
  parameter int THRESHOLD = fslc_pkg::ThresholdDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fslc_req_if.sink   req_i,
  fslc_rsp_if.source rsp_o
);
  import fslc_pkg::*;

  fslc_cmd_t cmd;
  fslc_sts_t sts;

  fslc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fslc_dp #(
    .THRESHOLD (THRESHOLD)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_cmd_i         (req_i.cmd),
    .req_key_i         (req_i.lookup_key),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_outcome_o     (rsp_o.outcome),
    .rsp_slot_o        (rsp_o.slot),
    .rsp_evicted_key_o (rsp_o.evicted_key)
  );

endmodule

`default_nettype wire

// ===== sv/fslc_ctrl.sv =====
// Controller for the texture cache: accept, scan sequencing and result hand-off.
// Depends on fslc_pkg.
`default_nettype none

module fslc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  input  wire logic                req_cmd_i,
  output logic                     req_ready_o,
  input  wire fslc_pkg::fslc_sts_t sts_i,
  output fslc_pkg::fslc_cmd_t      cmd_o
);
  import fslc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_cmd_i == CmdTick) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_LAST;
      end
      S_LAST: state_d = S_FIN;
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fslc_dp.sv =====
// Datapath for the texture cache: key and stamp memories, valid bits, scan
// trackers, frame counter, occupancy and result register. Depends on fslc_pkg.
`default_nettype none

module fslc_dp #(
  parameter int THRESHOLD = fslc_pkg::ThresholdDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fslc_pkg::fslc_cmd_t           cmd_i,
  output fslc_pkg::fslc_sts_t                sts_o,
  input  wire logic                          req_cmd_i,
  input  wire logic [fslc_pkg::KeyW-1:0]     req_key_i,
  input  wire logic                          rsp_ready_i,
  output logic                               rsp_valid_o,
  output logic [fslc_pkg::OutcomeW-1:0]      rsp_outcome_o,
  output logic [fslc_pkg::SlotW-1:0]         rsp_slot_o,
  output logic [fslc_pkg::KeyW-1:0]          rsp_evicted_key_o
);
  import fslc_pkg::*;

  localparam logic [ThreshW-1:0] Thr = ThreshW'(THRESHOLD);

  logic [KeyW-1:0]   key_mem   [EntryCount];
  logic [StampW-1:0] stamp_mem [EntryCount];
  logic [EntryCount-1:0] valid_q;

  logic [StampW-1:0] frame_q;
  logic [SlotW-1:0]  occ_q;
  logic              tick_q;
  logic [KeyW-1:0]   key_q;

  logic [SlotW-1:0]  addr_q;
  logic              rd_live_q;
  logic              rd_valid_q;
  logic [SlotW-1:0]  rd_idx_q;
  logic [KeyW-1:0]   rd_key_q;
  logic [StampW-1:0] rd_stamp_q;

  logic              hit_q, vic_q, free_q;
  logic [SlotW-1:0]  hit_idx_q, vic_idx_q, free_idx_q;
  logic [StampW-1:0] best_q;
  logic [KeyW-1:0]   vic_key_q;

  logic              evict;
  logic              has_slot;
  logic [SlotW-1:0]  new_slot;
  logic              mem_we;
  logic [SlotW-1:0]  mem_addr;

  logic                rsp_valid_q;
  logic [OutcomeW-1:0] rsp_outcome_q;
  logic [SlotW-1:0]    rsp_slot_q;
  logic [KeyW-1:0]     rsp_evicted_q;

  assign evict    = ({{(ThreshW-SlotW){1'b0}}, occ_q} > Thr) && vic_q;
  assign has_slot = evict || free_q;
  assign new_slot = (evict && !(free_q && (free_idx_q < vic_idx_q))) ? vic_idx_q
                                                                      : free_idx_q;
  assign mem_we   = cmd_i.finish && !tick_q && (hit_q || has_slot);
  assign mem_addr = hit_q ? hit_idx_q : new_slot;

  assign sts_o.scan_last = (addr_q == LastSlot);
  assign sts_o.out_busy  = rsp_valid_q && !rsp_ready_i;

  // memories: write on commit, registered read during scan
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[mem_addr] <= frame_q;
      if (!hit_q) key_mem[mem_addr] <= key_q;
    end
    rd_key_q   <= key_mem[addr_q];
    rd_stamp_q <= stamp_mem[addr_q];
    rd_valid_q <= valid_q[addr_q];
    rd_idx_q   <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_live_q <= 1'b0;
    end else begin
      rd_live_q <= cmd_i.scan_step;
      if (cmd_i.load) begin
        addr_q <= '0;
      end else if (cmd_i.scan_step) begin
        addr_q <= addr_q + SlotW'(1);
      end
    end
  end

  // scan trackers: first match, oldest stamp below frame, lowest free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      vic_q      <= 1'b0;
      free_q     <= 1'b0;
      best_q     <= '0;
      tick_q     <= 1'b0;
      key_q      <= '0;
      hit_idx_q  <= '0;
      vic_idx_q  <= '0;
      free_idx_q <= '0;
      vic_key_q  <= '0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      free_q <= 1'b0;
      best_q <= frame_q;
      tick_q <= req_cmd_i;
      key_q  <= req_key_i;
    end else if (rd_live_q) begin
      if (rd_valid_q && (rd_key_q == key_q) && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
      if (rd_valid_q && (rd_stamp_q < best_q)) begin
        vic_q     <= 1'b1;
        vic_idx_q <= rd_idx_q;
        best_q    <= rd_stamp_q;
        vic_key_q <= rd_key_q;
      end
      if (!rd_valid_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // commit state and load the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      occ_q         <= '0;
      frame_q       <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_outcome_q <= '0;
      rsp_slot_q    <= '0;
      rsp_evicted_q <= '0;
    end else begin
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (tick_q) begin
          rsp_outcome_q <= OutTick;
          rsp_slot_q    <= '0;
          rsp_evicted_q <= '0;
          if (frame_q != FrameTop) frame_q <= frame_q + StampW'(1);
        end else if (hit_q) begin
          rsp_outcome_q <= OutHit;
          rsp_slot_q    <= hit_idx_q;
          rsp_evicted_q <= '0;
        end else if (has_slot) begin
          if (evict) begin
            if (vic_idx_q != new_slot) valid_q[vic_idx_q] <= 1'b0;
            rsp_outcome_q <= OutEvicted;
            rsp_evicted_q <= vic_key_q;
          end else begin
            rsp_outcome_q <= OutStored;
            rsp_evicted_q <= '0;
            occ_q         <= occ_q + SlotW'(1);
          end
          valid_q[new_slot] <= 1'b1;
          rsp_slot_q        <= new_slot;
        end else begin
          rsp_outcome_q <= OutNoRoom;
          rsp_slot_q    <= '0;
          rsp_evicted_q <= '0;
        end
      end
    end
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_outcome_o     = rsp_outcome_q;
  assign rsp_slot_o        = rsp_slot_q;
  assign rsp_evicted_key_o = rsp_evicted_q;

endmodule

`default_nettype wire

// ===== tb/frame_stamped_lru_texture_cache_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for frame_stamped_lru_texture_cache_top: directed table then random
// frames of lookups and ticks; replies checked against typed table rows or a cache predictor.
// Depends on fslc_pkg, fslc_req_if, fslc_rsp_if and the cache RTL.

module frame_stamped_lru_texture_cache_top_test;
  import fslc_pkg::*;

  localparam int          CacheThreshold = ThresholdDef;
  localparam int          ClkPeriod      = 10;
  localparam int          LookupLatency  = 132;
  localparam int          ItemTarget     = 1600;
  localparam int          KeyPoolSize    = 176;
  localparam int          DrainLimit     = 20000;
  localparam int          HoldOffCycles  = 800;
  localparam longint      TimeoutCycles  = 2_500_000;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SlotW-1:0]    slot;
    logic [KeyW-1:0]     evicted_key;
  } cache_reply_t;

  typedef struct {
    logic            cmd;
    logic [KeyW-1:0] key;
    int unsigned     count;
    bit              typed;
    cache_reply_t    reply;
  } plan_row_t;

  typedef enum logic [1:0] {RxOpen, RxRandom, RxSparse} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fslc_req_if req ();
  fslc_rsp_if rsp ();

  frame_stamped_lru_texture_cache_top #(
    .THRESHOLD(CacheThreshold)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // cache predictor state
  bit              held [EntryCount];
  logic [KeyW-1:0] held_key [EntryCount];
  logic [StampW-1:0] held_stamp [EntryCount];
  logic [StampW-1:0] frame_now;
  int unsigned     fill_count;

  cache_reply_t    pending_replies [$];
  plan_row_t       plan [$];
  logic [KeyW-1:0] key_pool [KeyPoolSize];

  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned hits_seen, fills_seen, evictions_seen, refusals_seen, ticks_seen;

  function automatic cache_reply_t cache_access(input logic c, input logic [KeyW-1:0] k);
    cache_reply_t      r;
    int                victim;
    int                free_slot;
    logic [StampW-1:0] oldest;
    r = '0;
    if (c == CmdTick) begin
      if (frame_now != FrameTop) frame_now++;
      r.outcome = OutTick;
      return r;
    end
    for (int i = 0; i < EntryCount; i++) begin
      if (held[i] && held_key[i] == k) begin
        held_stamp[i] = frame_now;
        r.outcome = OutHit;
        r.slot = SlotW'(i);
        return r;
      end
    end
    r.outcome = OutStored;
    if (fill_count > CacheThreshold) begin
      victim = -1;
      oldest = frame_now;
      for (int i = 0; i < EntryCount; i++) begin
        if (held[i] && held_stamp[i] < oldest) begin
          oldest = held_stamp[i];
          victim = i;
        end
      end
      if (victim >= 0) begin
        r.evicted_key = held_key[victim];
        held[victim] = 1'b0;
        fill_count--;
        r.outcome = OutEvicted;
      end
    end
    free_slot = -1;
    for (int i = 0; i < EntryCount; i++) begin
      if (!held[i]) begin
        free_slot = i;
        break;
      end
    end
    if (free_slot < 0) begin
      r = '0;
      r.outcome = OutNoRoom;
      return r;
    end
    held[free_slot] = 1'b1;
    held_key[free_slot] = k;
    held_stamp[free_slot] = frame_now;
    fill_count++;
    r.slot = SlotW'(free_slot);
    return r;
  endfunction

  function automatic logic [KeyW-1:0] random_key();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KeyPoolSize - 1)];
    return random_key();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 200);
  endfunction

  task automatic add_row(input logic c, input logic [KeyW-1:0] k, input int unsigned n,
                         input bit typed, input logic [OutcomeW-1:0] oc,
                         input logic [SlotW-1:0] sl);
    plan_row_t row;
    row.cmd = c;
    row.key = k;
    row.count = n;
    row.typed = typed;
    row.reply = '{outcome: oc, slot: sl, evicted_key: '0};
    plan.push_back(row);
  endtask

  // enter and leave at a falling edge; hold the beat until accepted
  task automatic send_beat(input logic c, input logic [KeyW-1:0] k, input bit typed,
                           input cache_reply_t typed_reply);
    cache_reply_t predicted;
    int unsigned  gap;
    if (burst_left == 0) begin
      req.valid = 1'b0;
      gap = pick_gap();
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    req.valid = 1'b1;
    req.cmd = c;
    req.lookup_key = k;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predicted = cache_access(c, k);
    pending_replies.push_back(typed ? typed_reply : predicted);
    beats_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic flag_field(input string field, input longint unsigned want,
                            input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s of reply %0d: expected 'h%0h, got 'h%0h",
               field, results_seen, want, got);
  endtask

  // sender
  initial begin
    int unsigned  kind;
    int unsigned  n;
    int unsigned  waited;
    cache_reply_t none;
    none = '0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.cmd = CmdLookup;
    req.lookup_key = '0;
    frame_now = '0;
    fill_count = 0;
    burst_left = 0;
    for (int i = 0; i < KeyPoolSize; i++)
      key_pool[i] = (i < 32) ? KeyW'(48'h0000_1000_0000 + i) : random_key();

    add_row(CmdLookup, '0,               1,   1, OutStored, 8'd0);
    add_row(CmdLookup, '1,               1,   1, OutStored, 8'd1);
    add_row(CmdLookup, '0,               1,   1, OutHit,    8'd0);
    add_row(CmdTick,   '0,               1,   1, OutTick,   8'd0);
    add_row(CmdLookup, 48'hAAAA_AAAA_AAAA, 1, 0, OutHit,    8'd0);
    add_row(CmdLookup, 48'h5555_5555_5555, 1, 0, OutHit,    8'd0);
    add_row(CmdLookup, 48'h0000_1000_0000, 125, 0, OutHit,  8'd0);
    add_row(CmdLookup, '1,               1,   1, OutHit,    8'd1);
    add_row(CmdLookup, 48'h8000_0000_0000, 1, 0, OutHit,    8'd0);
    add_row(CmdLookup, 48'h0000_0000_0001, 1, 1, OutNoRoom, 8'd0);
    add_row(CmdTick,   '1,               1,   1, OutTick,   8'd0);
    add_row(CmdLookup, 48'h0000_1000_0000, 1, 0, OutHit,    8'd0);
    add_row(CmdLookup, 48'h0000_0000_0001, 1, 0, OutHit,    8'd0);
    add_row(CmdTick,   '0,               3,   1, OutTick,   8'd0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      for (int unsigned j = 0; j < plan[r].count; j++)
        send_beat(plan[r].cmd, plan[r].key + KeyW'(j), plan[r].typed, plan[r].reply);
    end

    while (beats_sent < ItemTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = $urandom_range(0, 12);
        repeat (n) send_beat(CmdLookup, pick_key(), 1'b0, none);
        send_beat(CmdTick, random_key(), 1'b0, none);
      end else if (kind < 85) begin
        n = $urandom_range(80, 220);
        repeat (n) send_beat(CmdLookup, pick_key(), 1'b0, none);
        send_beat(CmdTick, random_key(), 1'b0, none);
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) send_beat($urandom_range(0, 1) ? CmdTick : CmdLookup, random_key(), 1'b0, none);
      end
    end
    req.valid = 1'b0;

    waited = 0;
    while (pending_replies.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LookupLatency + 8) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      mismatches++;
      $display("%0d expected replies never arrived", pending_replies.size());
    end
    $display("covered %0d beats: %0d hits, %0d fills, %0d evictions, %0d refusals on a full store,",
             beats_sent, hits_seen, fills_seen, evictions_seen, refusals_seen);
    $display("%0d frame ticks, %0d mismatches", ticks_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: stall patterns plus occasional long hold-offs
  initial begin
    rx_mode_e    mode;
    int unsigned pattern_left;
    int unsigned hold_left;
    int unsigned hold_at;
    rsp.ready = 1'b0;
    mode = RxOpen;
    pattern_left = 0;
    hold_left = 0;
    hold_at = 200;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && results_seen >= hold_at) begin
        hold_left = HoldOffCycles;
        hold_at += 600;
      end
      if (hold_left != 0) begin
        rsp.ready = 1'b0;
        hold_left--;
      end else begin
        if (pattern_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          pattern_left = $urandom_range(20, 300);
        end
        pattern_left--;
        case (mode)
          RxOpen:   rsp.ready = 1'b1;
          RxRandom: rsp.ready = $urandom_range(0, 1);
          default:  rsp.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  cache_reply_t want;

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply with nothing expected: outcome %0d slot %0d evicted 'h%0h",
                   rsp.outcome, rsp.slot, rsp.evicted_key);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.outcome !== want.outcome) flag_field("outcome", want.outcome, rsp.outcome);
        if (rsp.slot !== want.slot) flag_field("slot", want.slot, rsp.slot);
        if (rsp.evicted_key !== want.evicted_key)
          flag_field("evicted_key", want.evicted_key, rsp.evicted_key);
        case (want.outcome)
          OutHit:     hits_seen++;
          OutStored:  fills_seen++;
          OutEvicted: evictions_seen++;
          OutNoRoom:  refusals_seen++;
          default:    ticks_seen++;
        endcase
      end
      results_seen++;
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fslc_pkg.sv
sv/fslc_req_if.sv
sv/fslc_rsp_if.sv
sv/fslc_ctrl.sv
sv/fslc_dp.sv
sv/frame_stamped_lru_texture_cache_top.sv
tb/frame_stamped_lru_texture_cache_top_test.sv
